>>> rtl/marwt_pkg.sv
// ----------------------------------------------------------------------------
// marwt_pkg: shared types and codes for the route winner table
// Slot layout, operation and status codes, result bundle and the route
// preference compare.
// ----------------------------------------------------------------------------
package marwt_pkg;

    // default table depth
    localparam int MAX_AREAS_DEF = 8;

    // operation codes (five to seven act as read winner)
    localparam logic [2:0] FUNC_ADD     = 3'd0;
    localparam logic [2:0] FUNC_REPLACE = 3'd1;
    localparam logic [2:0] FUNC_DELETE  = 3'd2;
    localparam logic [2:0] FUNC_LOOKUP  = 3'd3;
    localparam logic [2:0] FUNC_READ    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // one stored route
    typedef struct packed {
        logic [31:0] area;
        logic [1:0]  kind;
        logic [23:0] cost;
        logic [31:0] hop;
    } slot_t;

    // route fields returned by a lookup
    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] cost;
        logic [31:0] hop;
    } found_t;

    // one result item
    typedef struct packed {
        logic [1:0] status;
        logic       changed;
        logic       empty;
        slot_t      winner;
        found_t     found;
    } res_t;

    // true when route a is preferred over route b:
    // lower path type, then lower cost, then higher area id
    function automatic logic better(input slot_t a, input slot_t b);
        logic res;
        res = (a.kind < b.kind) ||
              ((a.kind == b.kind) &&
               ((a.cost < b.cost) ||
                ((a.cost == b.cost) && (a.area > b.area))));
        return res;
    endfunction

endpackage

>>> rtl/marwt_slot_mem.sv
// ----------------------------------------------------------------------------
// marwt_slot_mem: route slot storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module marwt_slot_mem #(
    parameter int DEPTH = marwt_pkg::MAX_AREAS_DEF
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  marwt_pkg::slot_t          wr_data,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output marwt_pkg::slot_t          rd_data
);

    marwt_pkg::slot_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/marwt_seq.sv
// ----------------------------------------------------------------------------
// marwt_seq: operation sequencer
// Scans the slot memory for the area, applies the update, on a change rescans
// for the winner and builds the result item. Valid bits and winner live here.
// ----------------------------------------------------------------------------
module marwt_seq #(
    parameter int MAX_AREAS = marwt_pkg::MAX_AREAS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command side
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    func,
    input  marwt_pkg::slot_t              route,
    // result side
    output logic                          res_valid,
    input  logic                          res_ready,
    output marwt_pkg::res_t               res,
    // slot memory
    output logic                          mem_wr_en,
    output logic [$clog2(MAX_AREAS)-1:0]  mem_wr_addr,
    output marwt_pkg::slot_t              mem_wr_data,
    output logic [$clog2(MAX_AREAS)-1:0]  mem_rd_addr,
    input  marwt_pkg::slot_t              mem_rd_data
);

    localparam int AW = $clog2(MAX_AREAS);
    localparam int CW = $clog2(MAX_AREAS + 1);
    localparam logic [CW-1:0] CNT_END = CW'(MAX_AREAS);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_PICK   = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // control state
    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [MAX_AREAS-1:0] valid_reg, valid_next;
    logic                 win_present_reg, win_present_next;
    logic [AW-1:0]        win_slot_reg, win_slot_next;
    logic                 hit_reg, hit_next;
    logic                 best_have_reg, best_have_next;

    // payload state
    logic [2:0]           func_reg, func_next;
    marwt_pkg::slot_t     key_reg, key_next;
    logic [AW-1:0]        rd_slot_reg, rd_slot_next;
    logic [AW-1:0]        hit_slot_reg, hit_slot_next;
    logic [AW-1:0]        touch_slot_reg, touch_slot_next;
    marwt_pkg::slot_t     best_reg, best_next;
    logic [AW-1:0]        best_slot_reg, best_slot_next;
    marwt_pkg::slot_t     win_data_reg, win_data_next;
    logic [1:0]           status_reg, status_next;
    logic                 changed_reg, changed_next;
    marwt_pkg::found_t    found_reg, found_next;

    // lowest free slot
    logic                 free_any;
    logic [AW-1:0]        free_slot;

    always_comb
    begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int i = MAX_AREAS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any  = 1'b1;
                free_slot = AW'(i);
            end
        end
    end

    // next-state logic
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        rd_pend_next     = rd_pend_reg;
        valid_next       = valid_reg;
        win_present_next = win_present_reg;
        win_slot_next    = win_slot_reg;
        hit_next         = hit_reg;
        best_have_next   = best_have_reg;
        func_next        = func_reg;
        key_next         = key_reg;
        rd_slot_next     = rd_slot_reg;
        hit_slot_next    = hit_slot_reg;
        touch_slot_next  = touch_slot_reg;
        best_next        = best_reg;
        best_slot_next   = best_slot_reg;
        win_data_next    = win_data_reg;
        status_next      = status_reg;
        changed_next     = changed_reg;
        found_next       = found_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = hit_slot_reg;
        mem_wr_data = key_reg;
        mem_rd_addr = cnt_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next    = func;
                    key_next     = route;
                    cnt_next     = '0;
                    rd_pend_next = 1'b0;
                    hit_next     = 1'b0;
                    found_next   = '0;
                    state_next   = S_FIND;
                end
            end

            // area search: one read per cycle, data checked in the next cycle
            S_FIND:
            begin
                if (rd_pend_reg && valid_reg[rd_slot_reg] &&
                    (mem_rd_data.area == key_reg.area))
                begin
                    hit_next      = 1'b1;
                    hit_slot_next = rd_slot_reg;
                    if (func_reg == marwt_pkg::FUNC_LOOKUP)
                    begin
                        found_next.kind = mem_rd_data.kind;
                        found_next.cost = mem_rd_data.cost;
                        found_next.hop  = mem_rd_data.hop;
                    end
                end
                if (cnt_reg == CNT_END)
                begin
                    rd_pend_next = 1'b0;
                    state_next   = S_DECIDE;
                end
                else
                begin
                    rd_pend_next = 1'b1;
                    rd_slot_next = cnt_reg[AW-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
            end

            // apply the operation
            S_DECIDE:
            begin
                status_next    = marwt_pkg::ST_OK;
                changed_next   = 1'b0;
                state_next     = S_DONE;
                cnt_next       = '0;
                rd_pend_next   = 1'b0;
                best_have_next = 1'b0;
                case (func_reg)
                    marwt_pkg::FUNC_ADD, marwt_pkg::FUNC_REPLACE:
                    begin
                        if (hit_reg && (func_reg == marwt_pkg::FUNC_ADD))
                        begin
                            status_next = marwt_pkg::ST_PRESENT;
                        end
                        else if (hit_reg || free_any)
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = hit_reg ? hit_slot_reg : free_slot;
                            valid_next[mem_wr_addr] = 1'b1;
                            touch_slot_next = mem_wr_addr;
                            state_next  = S_PICK;
                        end
                        else
                        begin
                            status_next = marwt_pkg::ST_FULL;
                        end
                    end
                    marwt_pkg::FUNC_DELETE:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = marwt_pkg::ST_ABSENT;
                        end
                        else
                        begin
                            valid_next[hit_slot_reg] = 1'b0;
                            touch_slot_next = hit_slot_reg;
                            state_next      = S_PICK;
                        end
                    end
                    marwt_pkg::FUNC_LOOKUP:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = marwt_pkg::ST_ABSENT;
                        end
                    end
                    default:
                    begin
                        if (!win_present_reg)
                        begin
                            status_next = marwt_pkg::ST_ABSENT;
                        end
                    end
                endcase
            end

            // winner scan over all valid slots
            S_PICK:
            begin
                if (rd_pend_reg && valid_reg[rd_slot_reg] &&
                    (!best_have_reg || marwt_pkg::better(mem_rd_data, best_reg)))
                begin
                    best_have_next = 1'b1;
                    best_next      = mem_rd_data;
                    best_slot_next = rd_slot_reg;
                end
                if (cnt_reg == CNT_END)
                begin
                    rd_pend_next = 1'b0;
                    state_next   = S_FIN;
                end
                else
                begin
                    rd_pend_next = 1'b1;
                    rd_slot_next = cnt_reg[AW-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
            end

            // commit new winner, flag a change
            S_FIN:
            begin
                changed_next = (win_present_reg != best_have_reg) ||
                               (best_have_reg && (win_slot_reg != best_slot_reg)) ||
                               (win_present_reg && (win_slot_reg == touch_slot_reg)) ||
                               (best_have_reg && (best_slot_reg == touch_slot_reg));
                win_present_next = best_have_reg;
                win_slot_next    = best_have_reg ? best_slot_reg : '0;
                win_data_next    = best_reg;
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // handshake and result bundle
    assign in_stall      = (state_reg != S_IDLE);
    assign res_valid     = (state_reg == S_DONE);
    assign res.status    = status_reg;
    assign res.changed   = changed_reg;
    assign res.empty     = ~win_present_reg;
    assign res.winner    = win_present_reg ? win_data_reg : '0;
    assign res.found     = found_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            valid_reg       <= '0;
            win_present_reg <= 1'b0;
            win_slot_reg    <= '0;
            hit_reg         <= 1'b0;
            best_have_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            rd_pend_reg     <= rd_pend_next;
            valid_reg       <= valid_next;
            win_present_reg <= win_present_next;
            win_slot_reg    <= win_slot_next;
            hit_reg         <= hit_next;
            best_have_reg   <= best_have_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        rd_slot_reg    <= rd_slot_next;
        hit_slot_reg   <= hit_slot_next;
        touch_slot_reg <= touch_slot_next;
        best_reg       <= best_next;
        best_slot_reg  <= best_slot_next;
        win_data_reg   <= win_data_next;
        status_reg     <= status_next;
        changed_reg    <= changed_next;
        found_reg      <= found_next;
    end

endmodule

>>> rtl/multi_area_route_winner_table.sv
// ----------------------------------------------------------------------------
// multi_area_route_winner_table: per-destination route winner table
// Holds one route per area and reports the preferred route after each item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one command item (func, area_id,
//   path_kind, route_cost, next_hop). Output channel out_valid/out_stall
//   returns exactly one result item per command.
//   Each item first scans the slot memory for its area, one slot read per
//   cycle. Add, replace and delete that change the table rescan the memory
//   to pick the winner; lookups, reads and failed updates skip the rescan.
//   One item is worked on at a time: the next is taken once the sequencer
//   has passed its result to the output register and returned to idle, so
//   a new item is not accepted before the last one is through; the two
//   memory scans set the pace.
//   The result goes to an output register, so the next item is accepted
//   while a result waits; a stalled receiver holds the result and the
//   finished item behind it, and in_stall stays high until room frees up.
//   Reset clears all slot valid bits and the winner; slot contents are not
//   cleared and no sweep runs, so items are accepted right after reset.
// ----------------------------------------------------------------------------
module multi_area_route_winner_table #(
    parameter int MAX_AREAS = marwt_pkg::MAX_AREAS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [31:0] area_id,
    input  logic [1:0]  path_kind,
    input  logic [23:0] route_cost,
    input  logic [31:0] next_hop,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        winner_update,
    output logic        table_empty,
    output logic [31:0] winner_area,
    output logic [1:0]  winner_path_kind,
    output logic [23:0] winner_cost,
    output logic [31:0] winner_next_hop,
    output logic [1:0]  found_path_kind,
    output logic [23:0] found_cost,
    output logic [31:0] found_next_hop
);

    localparam int AW = $clog2(MAX_AREAS);

    marwt_pkg::slot_t route;
    marwt_pkg::slot_t mem_wr_data;
    marwt_pkg::slot_t mem_rd_data;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [AW-1:0]    mem_rd_addr;
    logic             res_valid;
    logic             res_ready;
    marwt_pkg::res_t  res;

    logic             out_valid_reg, out_valid_next;
    marwt_pkg::res_t  out_reg, out_next;

    assign route.area = area_id;
    assign route.kind = path_kind;
    assign route.cost = route_cost;
    assign route.hop  = next_hop;

    marwt_seq #(
        .MAX_AREAS (MAX_AREAS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .route       (route),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    marwt_slot_mem #(
        .DEPTH (MAX_AREAS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register: loads when empty or being drained
    assign res_ready = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // result ports
    assign out_valid        = out_valid_reg;
    assign status           = out_reg.status;
    assign winner_update    = out_reg.changed;
    assign table_empty      = out_reg.empty;
    assign winner_area      = out_reg.winner.area;
    assign winner_path_kind = out_reg.winner.kind;
    assign winner_cost      = out_reg.winner.cost;
    assign winner_next_hop  = out_reg.winner.hop;
    assign found_path_kind  = out_reg.found.kind;
    assign found_cost       = out_reg.found.cost;
    assign found_next_hop   = out_reg.found.hop;

endmodule
